FILE: rtl/deadline_timer_queue_unit_assert.svh
// assertion macros for the deadline timer queue
// expects clk and rst_n in the scope of use
`ifndef DEADLINE_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dtq_pkg.sv
// shared constants, types and helpers of the deadline timer queue
// no dependencies
package dtq_pkg;

    localparam int ENTRIES     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int AW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW          = $clog2(ENTRIES + 1);
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
    localparam logic [30:0] DELAY_SIGN = 31'h4000_0000;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_KILL  = 2'd1;
    localparam logic [1:0] OP_EXIST = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [2:0] KIND_FIRED = 3'd0;
    localparam logic [2:0] KIND_EXIST = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_FULL  = 3'd3;
    localparam logic [2:0] KIND_NONE  = 3'd4;

    typedef struct packed {
        logic [31:0] deadline;
        logic [30:0] period;
        logic [31:0] owner;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic        found;
        logic        last;
    } emit_t;

    function automatic logic [31:0] magnitude(input logic [30:0] p);
        logic [31:0] r;
        if ((p & DELAY_SIGN) != 31'd0)
            r = HALF_RANGE - {1'b0, p};
        else
            r = {1'b0, p};
        return r;
    endfunction

    // ring position of a logical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, b} + {1'b0, l};
        if (s >= (AW+1)'(ENTRIES))
            s = s - (AW+1)'(ENTRIES);
        return s[AW-1:0];
    endfunction

endpackage

FILE: rtl/deadline_timer_queue_unit.sv
// top level of the deadline timer queue: control sequencer over a ring-ordered timer ram
// depends on dtq_pkg, dtq_ram and deadline_timer_queue_unit_assert.svh
//
// channel  signals                                    dir
// in       in_valid in_ready opcode now delay         in
//          owner_id id_limit
// out      out_valid out_ready kind fired_id found    out
//          last
//
// one word at a time; in_ready is high only while the sequencer is idle
// set: forward scan that moves later entries up one per cycle; an empty table takes the
//   entry without a scan, and a full one answers with a full result
// kill and exists: one entry scanned per cycle through the ram read port
// tick: a backwards clock first scans the table and zeroes deadlines above half range; then
//   each expired timer fires from the head, and one with a negative period is re-armed by a set scan
// a stalled output holds the sequencer before its next result; reset empties the table at once
`include "deadline_timer_queue_unit_assert.svh"
module deadline_timer_queue_unit
    import dtq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [31:0]        now,
    input  logic signed [30:0] delay,
    input  logic [31:0]        owner_id,
    input  logic [31:0]        id_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic [31:0]        fired_id,
    output logic               found,
    output logic               last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_INS0  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_INSH  = 4'd4;
    localparam logic [3:0] S_KILL  = 4'd5;
    localparam logic [3:0] S_EXIST = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;
    localparam logic [3:0] S_FRD   = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_FPOST = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    ret_reg, ret_next;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   now_reg, now_next;
    logic [30:0]   dly_reg, dly_next;
    logic [31:0]   own_reg, own_next;
    logic [31:0]   lim_reg, lim_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] base_reg, base_next;
    logic [31:0]   last_tick_reg, last_tick_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          hit_reg, hit_next;
    logic [NW-1:0] n_reg, n_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [31:0]   pend_id_reg, pend_id_next;
    logic [30:0]   per_reg, per_next;
    logic [31:0]   ins_dl_reg, ins_dl_next;
    logic [30:0]   ins_per_reg, ins_per_next;
    logic [31:0]   ins_own_reg, ins_own_next;
    logic          rearm_reg, rearm_next;
    emit_t         emit_reg, emit_next;
    logic          out_valid_reg, out_valid_next;
    emit_t         out_reg, out_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        q;

    logic          scan_end;
    logic          kept;
    logic          hit_now;
    entry_t        new_entry;
    entry_t        cleared;

    dtq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign fired_id  = out_reg.id;
    assign found     = out_reg.found;
    assign last      = out_reg.last;

    assign scan_end  = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign kept      = !((q.owner >= own_reg) && (q.owner < lim_reg));
    assign hit_now   = hit_reg | (q.owner == own_reg);
    assign new_entry = '{deadline: ins_dl_reg, period: ins_per_reg, owner: ins_own_reg};
    assign cleared   = '{deadline: 32'd0, period: q.period, owner: q.owner};

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        dly_next        = dly_reg;
        own_next        = own_reg;
        lim_next        = lim_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        last_tick_next  = last_tick_reg;
        idx_next        = idx_reg;
        wr_next         = wr_reg;
        hit_next        = hit_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        per_next        = per_reg;
        ins_dl_next     = ins_dl_reg;
        ins_per_next    = ins_per_reg;
        ins_own_next    = ins_own_reg;
        rearm_next      = rearm_reg;
        emit_next       = emit_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = q;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    now_next   = now;
                    dly_next   = delay;
                    own_next   = owner_id;
                    lim_next   = id_limit;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next = '0;
                wr_next  = '0;
                hit_next = 1'b0;
                ram_raddr = phys(base_reg, AW'(0));
                unique case (op_reg)
                    OP_SET:
                    begin
                        if (count_reg == CW'(ENTRIES))
                        begin
                            emit_next  = '{kind: KIND_FULL, id: 32'd0, found: 1'b0, last: 1'b1};
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ins_dl_next  = now_reg + magnitude(dly_reg);
                            ins_per_next = dly_reg;
                            ins_own_next = own_reg;
                            rearm_next   = 1'b0;
                            state_next   = S_INS0;
                        end
                    end
                    OP_KILL:
                    begin
                        if (count_reg == '0)
                        begin
                            emit_next  = '{kind: KIND_DONE, id: 32'd0, found: 1'b0, last: 1'b1};
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_KILL;
                        end
                    end
                    OP_EXIST:
                    begin
                        if (count_reg == '0)
                        begin
                            emit_next  = '{kind: KIND_EXIST, id: 32'd0, found: 1'b0, last: 1'b1};
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_EXIST;
                        end
                    end
                    OP_TICK:
                    begin
                        last_tick_next  = now_reg;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                        if ((last_tick_reg > now_reg) && (count_reg != '0))
                            state_next = S_CLR;
                        else
                            state_next = S_FRD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS0:
            begin
                if (count_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = phys(base_reg, AW'(0));
                    ram_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    if (rearm_reg)
                    begin
                        state_next = S_FRD;
                    end
                    else
                    begin
                        emit_next  = '{kind: KIND_DONE, id: 32'd0, found: 1'b0, last: 1'b1};
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ram_raddr  = phys(base_reg, AW'(0));
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                // once placed, each entry is swapped with the one carried along
                if (hit_reg || (ins_dl_reg < q.deadline))
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = phys(base_reg, idx_reg);
                    ram_wdata    = new_entry;
                    ins_dl_next  = q.deadline;
                    ins_per_next = q.period;
                    ins_own_next = q.owner;
                    hit_next     = 1'b1;
                end
                if (scan_end)
                begin
                    state_next = S_INSH;
                end
                else
                begin
                    ram_raddr = phys(base_reg, idx_reg + AW'(1));
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_INSH:
            begin
                ram_we     = 1'b1;
                ram_waddr  = phys(base_reg, count_reg[AW-1:0]);
                ram_wdata  = new_entry;
                count_next = count_reg + CW'(1);
                if (rearm_reg)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    emit_next  = '{kind: KIND_DONE, id: 32'd0, found: 1'b0, last: 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_KILL:
            begin
                if (kept)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(base_reg, wr_reg[AW-1:0]);
                    ram_wdata = q;
                    wr_next   = wr_reg + CW'(1);
                end
                if (scan_end)
                begin
                    count_next = kept ? (wr_reg + CW'(1)) : wr_reg;
                    emit_next  = '{kind: KIND_DONE, id: 32'd0, found: 1'b0, last: 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_raddr = phys(base_reg, idx_reg + AW'(1));
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_EXIST:
            begin
                hit_next = hit_now;
                if (scan_end)
                begin
                    emit_next  = '{kind: KIND_EXIST, id: 32'd0, found: hit_now, last: 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_raddr = phys(base_reg, idx_reg + AW'(1));
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_CLR:
            begin
                if (q.deadline > HALF_RANGE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(base_reg, idx_reg);
                    ram_wdata = cleared;
                end
                if (scan_end)
                begin
                    state_next = S_FRD;
                end
                else
                begin
                    ram_raddr = phys(base_reg, idx_reg + AW'(1));
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_FRD:
            begin
                if ((n_reg == NW'(MAX_RESULTS)) || (count_reg == '0))
                begin
                    emit_next  = '{kind: pend_valid_reg ? KIND_FIRED : KIND_NONE,
                                   id: pend_valid_reg ? pend_id_reg : 32'd0,
                                   found: 1'b0, last: 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_raddr  = phys(base_reg, AW'(0));
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (q.deadline < now_reg)
                begin
                    base_next       = (base_reg == AW'(ENTRIES - 1)) ? '0 : (base_reg + AW'(1));
                    count_next      = count_reg - CW'(1);
                    n_next          = n_reg + NW'(1);
                    per_next        = q.period;
                    pend_id_next    = q.owner;
                    pend_valid_next = 1'b1;
                    emit_next       = '{kind: KIND_FIRED, id: pend_id_reg, found: 1'b0,
                                        last: 1'b0};
                    ret_next        = S_FPOST;
                    state_next      = pend_valid_reg ? S_EMIT : S_FPOST;
                end
                else
                begin
                    emit_next  = '{kind: pend_valid_reg ? KIND_FIRED : KIND_NONE,
                                   id: pend_valid_reg ? pend_id_reg : 32'd0,
                                   found: 1'b0, last: 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_FPOST:
            begin
                if ((per_reg & DELAY_SIGN) != 31'd0)
                begin
                    ins_dl_next  = now_reg + magnitude(per_reg);
                    ins_per_next = per_reg;
                    ins_own_next = pend_id_reg;
                    rearm_next   = 1'b1;
                    state_next   = S_INS0;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = emit_reg;
                    out_valid_next = 1'b1;
                    state_next     = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= '0;
            base_reg       <= '0;
            last_tick_reg  <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            rearm_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            count_reg      <= count_next;
            base_reg       <= base_next;
            last_tick_reg  <= last_tick_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            rearm_reg      <= rearm_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        now_reg     <= now_next;
        dly_reg     <= dly_next;
        own_reg     <= own_next;
        lim_reg     <= lim_next;
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        hit_reg     <= hit_next;
        pend_id_reg <= pend_id_next;
        per_reg     <= per_next;
        ins_dl_reg  <= ins_dl_next;
        ins_per_reg <= ins_per_next;
        ins_own_reg <= ins_own_next;
        emit_reg    <= emit_next;
        out_reg     <= out_next;
    end

    // table occupancy and per-tick fire count stay in range
    `DTQ_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(ENTRIES), "entry count overflow")
    `DTQ_ASSERT_IMP(a_fire_cap, 1'b1, n_reg <= NW'(MAX_RESULTS), "fire count overflow")
    // an accepted word goes straight to dispatch
    `DTQ_ASSERT_NEXT(a_accept_disp, in_valid && in_ready, state_reg == S_DISP,
        "accepted word not dispatched")
    // the ram is never written while idle
    `DTQ_ASSERT_IMP(a_idle_no_write, state_reg == S_IDLE, !ram_we, "ram write while idle")

endmodule

FILE: rtl/dtq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
